// File: hdl/srsp_pkg.sv
// Shared types, report id codes and report size / kind tables for the
// sensor report stream parser. No dependencies.
`default_nettype none

package srsp_pkg;

    localparam int DEF_MAX_REPORT_BYTES = 14;

    localparam int SIZE_W = 4;
    localparam int KIND_W = 3;

    localparam logic [7:0] ID_TIMESTAMP = 8'hFB;
    localparam logic [2:0] TS_SKIP_BYTES = 3'd4;
    localparam logic [1:0] ACCURACY_MASK = 2'h3;

    localparam logic [7:0] ID_ACCEL     = 8'h01;
    localparam logic [7:0] ID_GYRO      = 8'h02;
    localparam logic [7:0] ID_MAG       = 8'h03;
    localparam logic [7:0] ID_LIN_ACCEL = 8'h04;
    localparam logic [7:0] ID_ROT_VEC   = 8'h05;
    localparam logic [7:0] ID_GRAVITY   = 8'h06;
    localparam logic [7:0] ID_GAME_ROT  = 8'h08;
    localparam logic [7:0] ID_GEO_ROT   = 8'h09;
    localparam logic [7:0] ID_TAP       = 8'h0E;
    localparam logic [7:0] ID_STEP_DET  = 8'h0F;
    localparam logic [7:0] ID_STEP_CNT  = 8'h10;
    localparam logic [7:0] ID_SIG_MOT   = 8'h11;
    localparam logic [7:0] ID_STAB_CLS  = 8'h13;
    localparam logic [7:0] ID_SHAKE     = 8'h14;
    localparam logic [7:0] ID_FLIP      = 8'h15;

    localparam logic [SIZE_W-1:0] SIZE_LONG     = 4'd14;
    localparam logic [SIZE_W-1:0] SIZE_GAME     = 4'd12;
    localparam logic [SIZE_W-1:0] SIZE_EVENT    = 4'd6;
    localparam logic [SIZE_W-1:0] SIZE_SIG_MOT  = 4'd5;
    localparam logic [SIZE_W-1:0] SIZE_ID_ONLY  = 4'd1;
    localparam logic [SIZE_W-1:0] SIZE_UNKNOWN  = 4'd0;

    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GAME_ROT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ROT_VEC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACCEL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GYRO      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MAG       = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LIN_ACCEL = 3'd6;
    localparam logic [KIND_W-1:0] KIND_GRAVITY   = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] channel_number;
        logic       first_of_packet;
        logic       last_of_packet;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  report_kind;
        logic [7:0]         sequence_number;
        logic [1:0]         accuracy_status;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] z_value;
        logic signed [15:0] real_value;
        logic signed [15:0] heading_accuracy;
        logic               packet_done;
        logic               any_report_found;
    } result_t;

    function automatic logic [SIZE_W-1:0] size_of_id(input logic [7:0] id);
        logic [SIZE_W-1:0] sz;
        case (id) inside
            ID_GAME_ROT, ID_GEO_ROT: sz = SIZE_GAME;
            ID_ACCEL, ID_GYRO, ID_MAG, ID_LIN_ACCEL, ID_ROT_VEC, ID_GRAVITY: sz = SIZE_LONG;
            ID_TAP, ID_STEP_DET, ID_STEP_CNT: sz = SIZE_EVENT;
            ID_SIG_MOT: sz = SIZE_SIG_MOT;
            ID_STAB_CLS, ID_SHAKE, ID_FLIP: sz = SIZE_ID_ONLY;
            default: sz = SIZE_UNKNOWN;
        endcase
        return sz;
    endfunction

    function automatic logic [KIND_W-1:0] kind_of_id(input logic [7:0] id);
        logic [KIND_W-1:0] k;
        case (id)
            ID_GAME_ROT:  k = KIND_GAME_ROT;
            ID_ROT_VEC:   k = KIND_ROT_VEC;
            ID_ACCEL:     k = KIND_ACCEL;
            ID_GYRO:      k = KIND_GYRO;
            ID_MAG:       k = KIND_MAG;
            ID_LIN_ACCEL: k = KIND_LIN_ACCEL;
            ID_GRAVITY:   k = KIND_GRAVITY;
            default:      k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hdl/srsp_input_stage.sv
// Input register of the parser: captures one byte beat and holds it
// until the parse stage takes it. Depends on srsp_pkg.
`default_nettype none

module srsp_input_stage
    import srsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    input  wire logic     advance,
    output logic          held_valid,
    output in_item_t      held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // a held beat that cannot move on blocks the next one
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// File: hdl/srsp_parse_core.sv
// Per-byte parse logic and packet / report state of the parser, including
// the report byte store. Depends on srsp_pkg.
`default_nettype none

module srsp_parse_core
    import srsp_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = DEF_MAX_REPORT_BYTES
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire in_item_t   item,
    input  wire logic [7:0] channel_mask,
    output logic            have_result,
    output result_t         result
);

    localparam int STORE_DEPTH = MAX_REPORT_BYTES - 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(MAX_REPORT_BYTES + 1);

    logic [2:0]        skip_reg, skip_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [7:0]        code_reg, code_next;
    logic              halted_reg, halted_next;
    logic              accepted_reg, accepted_next;
    logic              found_reg, found_next;

    logic [7:0]        store_reg [STORE_DEPTH];
    logic [7:0]        view [STORE_DEPTH];
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              finish;
    logic              have_report;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] sz;
    logic [7:0]        b;

    assign b      = item.data_byte;
    assign wr_idx = IDX_W'(pos_reg - 1'b1);
    assign sz     = size_of_id(b);

    always_comb
    begin
        skip_next     = skip_reg;
        pos_next      = pos_reg;
        size_next     = size_reg;
        code_next     = code_reg;
        halted_next   = halted_reg;
        accepted_next = accepted_reg;
        found_next    = found_reg;
        wr_en         = 1'b0;
        finish        = 1'b0;
        have_report   = 1'b0;
        kind          = KIND_NONE;

        if (item.first_of_packet)
        begin
            skip_next     = '0;
            pos_next      = '0;
            size_next     = '0;
            halted_next   = 1'b0;
            found_next    = 1'b0;
            accepted_next = (item.channel_number[7:3] == 5'd0)
                            && channel_mask[item.channel_number[2:0]];
        end

        if (item.first_of_packet && accepted_next && b == ID_TIMESTAMP)
        begin
            skip_next = TS_SKIP_BYTES;
        end
        else if (accepted_next && !halted_next)
        begin
            if (skip_next != 3'd0)
            begin
                skip_next = skip_next - 3'd1;
            end
            else if (pos_next == '0)
            begin
                if (sz == SIZE_UNKNOWN)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    code_next = b;
                    size_next = sz;
                    pos_next  = POS_W'(1);
                    finish    = (sz == SIZE_ID_ONLY);
                end
            end
            else
            begin
                wr_en    = (pos_next <= POS_W'(STORE_DEPTH));
                pos_next = pos_next + 1'b1;
                finish   = (pos_next >= POS_W'(size_next));
            end
        end

        if (finish)
        begin
            kind     = kind_of_id(code_next);
            pos_next = '0;
            if (kind != KIND_NONE)
            begin
                have_report = 1'b1;
                found_next  = 1'b1;
            end
        end

        result = '0;
        if (have_report)
        begin
            result.report_kind     = kind;
            result.sequence_number = view[0];
            result.accuracy_status = view[1][1:0] & ACCURACY_MASK;
            result.x_value         = {view[4], view[3]};
            result.y_value         = {view[6], view[5]};
            result.z_value         = {view[8], view[7]};
            if (kind == KIND_GAME_ROT || kind == KIND_ROT_VEC)
            begin
                result.real_value = {view[10], view[9]};
            end
            if (kind == KIND_ROT_VEC)
            begin
                result.heading_accuracy = {view[12], view[11]};
            end
        end

        have_result = have_report;
        if (item.last_of_packet)
        begin
            result.packet_done      = 1'b1;
            result.any_report_found = found_next;
            accepted_next           = 1'b0;
            halted_next             = 1'b0;
            skip_next               = '0;
            pos_next                = '0;
            found_next              = 1'b0;
            have_result             = 1'b1;
        end
    end

    // the byte that completes a report is read straight from the input
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_view
        assign view[i] = (wr_en && wr_idx == IDX_W'(i)) ? b : store_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            store_reg[wr_idx] <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg     <= '0;
            pos_reg      <= '0;
            size_reg     <= '0;
            code_reg     <= '0;
            halted_reg   <= 1'b0;
            accepted_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (fire)
        begin
            skip_reg     <= skip_next;
            pos_reg      <= pos_next;
            size_reg     <= size_next;
            code_reg     <= code_next;
            halted_reg   <= halted_next;
            accepted_reg <= accepted_next;
            found_reg    <= found_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/srsp_result_stage.sv
// Result register of the parser: holds one result beat until the
// receiver takes it. Depends on srsp_pkg.
`default_nettype none

module srsp_result_stage
    import srsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire logic    have_result,
    input  wire result_t result,
    output logic         can_load,
    input  wire logic    out_stall,
    output logic         out_valid,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = can_load ? (fire && have_result) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && have_result)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// File: hdl/sensor_report_stream_parser.sv
// Top level of the sensor report stream parser: input register, parse core
// and result register, plus the channel mask register.
// Depends on srsp_pkg, srsp_input_stage, srsp_parse_core, srsp_result_stage.
//
// Usage:
//   Input channel: one payload byte per beat with its channel number and
//   first / last packet marks; a beat is taken when in_valid is high and
//   in_stall is low.
//   Output channel: one result beat per decoded sensor report and one on
//   every packet's last byte (a report completed by that byte is merged
//   into it); taken when out_valid is high and out_stall is low.
//   Config channel: cfg_data writes the accepted channel mask when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write only
//   while no beats are in flight.
//   A result passes the input register, then the result register.
//   Rate: one byte per cycle if out_stall is low, set by the single parse stage.
//   Reset: all packet state is cleared and the mask returns to 0x38.
//   When the receiver stalls with a result waiting, one more input beat is
//   held in the input register, then in_stall rises until the result is taken.
`default_nettype none

module sensor_report_stream_parser
    import srsp_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = DEF_MAX_REPORT_BYTES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        data_byte,
    input  wire logic [7:0]        channel_number,
    input  wire logic              first_of_packet,
    input  wire logic              last_of_packet,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             report_kind,
    output logic [7:0]             sequence_number,
    output logic [1:0]             accuracy_status,
    output logic signed [15:0]     x_value,
    output logic signed [15:0]     y_value,
    output logic signed [15:0]     z_value,
    output logic signed [15:0]     real_value,
    output logic signed [15:0]     heading_accuracy,
    output logic                   packet_done,
    output logic                   any_report_found
);

    localparam logic [7:0] MASK_RESET = 8'h38;

    logic [7:0] mask_reg;
    in_item_t   in_item;
    in_item_t   held_item;
    logic       held_valid;
    logic       can_load;
    logic       fire;
    logic       have_result;
    result_t    core_result;
    result_t    out_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mask_reg <= cfg_data;
        end
    end

    assign in_item.data_byte       = data_byte;
    assign in_item.channel_number  = channel_number;
    assign in_item.first_of_packet = first_of_packet;
    assign in_item.last_of_packet  = last_of_packet;

    // the held beat is parsed once the result register can take its outcome
    assign fire = held_valid && can_load;

    srsp_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (can_load),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    srsp_parse_core #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (held_item),
        .channel_mask (mask_reg),
        .have_result  (have_result),
        .result       (core_result)
    );

    srsp_result_stage u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .have_result (have_result),
        .result      (core_result),
        .can_load    (can_load),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_result  (out_result)
    );

    assign report_kind      = out_result.report_kind;
    assign sequence_number  = out_result.sequence_number;
    assign accuracy_status  = out_result.accuracy_status;
    assign x_value          = out_result.x_value;
    assign y_value          = out_result.y_value;
    assign z_value          = out_result.z_value;
    assign real_value       = out_result.real_value;
    assign heading_accuracy = out_result.heading_accuracy;
    assign packet_done      = out_result.packet_done;
    assign any_report_found = out_result.any_report_found;

    // a parsed last byte always shows up as a packet-end beat
    a_last_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && held_item.last_of_packet |=> out_valid && packet_done)
        else $error("last byte parsed without a packet-end beat");

    a_found_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && any_report_found |-> packet_done)
        else $error("report-found flag outside a packet-end beat");

    a_empty_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == KIND_NONE |-> packet_done)
        else $error("report-less beat that is not a packet end");

    // a beat parsed with no result leaves the output register empty
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !have_result |=> !out_valid)
        else $error("result beat appeared without a parsed result");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for sensor_report_stream_parser: directed packets from a
// table, then random packets checked against a behavioral decoder of the reports.
// Depends on srsp_pkg and the parser RTL under hdl/.
`default_nettype none

module testbench;
    import srsp_pkg::*;

    localparam int BUF_DEPTH = DEF_MAX_REPORT_BYTES - 1;
    localparam int BEATS_PER_PHASE = 250;
    localparam int N_PHASES = 8;

    localparam logic [7:0] SENSOR_IDS [7] = '{ID_ACCEL, ID_GYRO, ID_MAG, ID_LIN_ACCEL,
                                              ID_ROT_VEC, ID_GRAVITY, ID_GAME_ROT};
    localparam logic [7:0] OTHER_IDS [8] = '{ID_GEO_ROT, ID_TAP, ID_STEP_DET, ID_STEP_CNT,
                                             ID_SIG_MOT, ID_STAB_CLS, ID_SHAKE, ID_FLIP};
    localparam logic [7:0] MASK_PLAN [N_PHASES] = '{8'hFF, 8'h00, 8'h81, 8'h38,
                                                    8'h7E, 8'h01, 8'h80, 8'hFF};

    typedef enum logic [1:0] {BY_MODEL, WANT_NONE, WANT_RESULT} check_e;

    typedef struct {
        in_item_t beat;
        check_e   chk;
        result_t  want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] data_byte = 8'h00;
    logic [7:0] channel_number = 8'h00;
    logic first_of_packet = 1'b0;
    logic last_of_packet = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = 8'h00;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] report_kind;
    logic [7:0] sequence_number;
    logic [1:0] accuracy_status;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic signed [15:0] z_value;
    logic signed [15:0] real_value;
    logic signed [15:0] heading_accuracy;
    logic packet_done;
    logic any_report_found;

    // decoder state
    logic [7:0] chan_mask = 8'h38;
    logic [2:0] ts_left = '0;
    logic [3:0] rpt_pos = '0;
    logic [3:0] rpt_len = '0;
    logic [7:0] rpt_id = '0;
    logic [7:0] rpt_buf [BUF_DEPTH] = '{default: 8'h00};
    bit halted = 1'b0;
    bit pkt_open = 1'b0;
    bit found_any = 1'b0;

    result_t pending_reports [$];
    script_row_t script [$];
    int beats_sent = 0;
    int error_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    sensor_report_stream_parser u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .channel_number   (channel_number),
        .first_of_packet  (first_of_packet),
        .last_of_packet   (last_of_packet),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .report_kind      (report_kind),
        .sequence_number  (sequence_number),
        .accuracy_status  (accuracy_status),
        .x_value          (x_value),
        .y_value          (y_value),
        .z_value          (z_value),
        .real_value       (real_value),
        .heading_accuracy (heading_accuracy),
        .packet_done      (packet_done),
        .any_report_found (any_report_found)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // report length including the id byte; zero for an unknown id
    function automatic logic [3:0] id_info(input logic [7:0] id, output logic [2:0] kind);
        logic [3:0] len;
        len = SIZE_UNKNOWN;
        kind = KIND_NONE;
        case (id)
            ID_ACCEL:      begin len = SIZE_LONG; kind = KIND_ACCEL;     end
            ID_GYRO:       begin len = SIZE_LONG; kind = KIND_GYRO;      end
            ID_MAG:        begin len = SIZE_LONG; kind = KIND_MAG;       end
            ID_LIN_ACCEL:  begin len = SIZE_LONG; kind = KIND_LIN_ACCEL; end
            ID_ROT_VEC:    begin len = SIZE_LONG; kind = KIND_ROT_VEC;   end
            ID_GRAVITY:    begin len = SIZE_LONG; kind = KIND_GRAVITY;   end
            ID_GAME_ROT:   begin len = SIZE_GAME; kind = KIND_GAME_ROT;  end
            ID_GEO_ROT:    len = SIZE_GAME;
            ID_TAP, ID_STEP_DET, ID_STEP_CNT: len = SIZE_EVENT;
            ID_SIG_MOT:    len = SIZE_SIG_MOT;
            ID_STAB_CLS, ID_SHAKE, ID_FLIP: len = SIZE_ID_ONLY;
            default: ;
        endcase
        return len;
    endfunction

    function automatic bit close_report(output result_t r);
        logic [2:0] kind;
        r = '0;
        void'(id_info(rpt_id, kind));
        rpt_pos = '0;
        if (kind == KIND_NONE)
            return 1'b0;
        found_any = 1'b1;
        r.report_kind = kind;
        r.sequence_number = rpt_buf[0];
        r.accuracy_status = rpt_buf[1][1:0];
        r.x_value = {rpt_buf[4], rpt_buf[3]};
        r.y_value = {rpt_buf[6], rpt_buf[5]};
        r.z_value = {rpt_buf[8], rpt_buf[7]};
        if (kind == KIND_GAME_ROT || kind == KIND_ROT_VEC)
            r.real_value = {rpt_buf[10], rpt_buf[9]};
        if (kind == KIND_ROT_VEC)
            r.heading_accuracy = {rpt_buf[12], rpt_buf[11]};
        return 1'b1;
    endfunction

    // advance the decoder by one beat; returns 1 when the beat yields a result
    function automatic bit decode_byte(input in_item_t it, output result_t r);
        logic [2:0] kind;
        logic [3:0] len;
        bit have;
        r = '0;
        have = 1'b0;
        if (it.first_of_packet)
        begin
            ts_left = '0;
            rpt_pos = '0;
            rpt_len = '0;
            halted = 1'b0;
            found_any = 1'b0;
            pkt_open = (it.channel_number < 8) && chan_mask[it.channel_number[2:0]];
        end
        if (it.first_of_packet && pkt_open && it.data_byte == ID_TIMESTAMP)
            ts_left = TS_SKIP_BYTES;
        else if (pkt_open && !halted)
        begin
            if (ts_left != 0)
                ts_left--;
            else if (rpt_pos == 0)
            begin
                len = id_info(it.data_byte, kind);
                if (len == SIZE_UNKNOWN)
                    halted = 1'b1;
                else
                begin
                    rpt_id = it.data_byte;
                    rpt_len = len;
                    rpt_pos = 4'd1;
                    if (len == SIZE_ID_ONLY)
                        have = close_report(r);
                end
            end
            else
            begin
                if (rpt_pos <= BUF_DEPTH)
                    rpt_buf[rpt_pos - 1] = it.data_byte;
                rpt_pos++;
                if (rpt_pos >= rpt_len)
                    have = close_report(r);
            end
        end
        if (it.last_of_packet)
        begin
            r.packet_done = 1'b1;
            r.any_report_found = found_any;
            pkt_open = 1'b0;
            halted = 1'b0;
            ts_left = '0;
            rpt_pos = '0;
            found_any = 1'b0;
            have = 1'b1;
        end
        return have;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf({"kind=%0d seq=%0d acc=%0d x=%0d y=%0d z=%0d real=%0d head=%0d",
                          " done=%0b found=%0b"},
                         r.report_kind, r.sequence_number, r.accuracy_status, r.x_value,
                         r.y_value, r.z_value, r.real_value, r.heading_accuracy,
                         r.packet_done, r.any_report_found);
    endfunction

    function automatic result_t done_only(input bit found);
        result_t r;
        r = '0;
        r.packet_done = 1'b1;
        r.any_report_found = found;
        return r;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.report_kind = report_kind;
            got.sequence_number = sequence_number;
            got.accuracy_status = accuracy_status;
            got.x_value = x_value;
            got.y_value = y_value;
            got.z_value = z_value;
            got.real_value = real_value;
            got.heading_accuracy = heading_accuracy;
            got.packet_done = packet_done;
            got.any_report_found = any_report_found;
            if (pending_reports.size() == 0)
                note_error($sformatf("result with none expected: %s", show(got)));
            else
            begin
                want = pending_reports.pop_front();
                if (got.report_kind !== want.report_kind
                    || got.sequence_number !== want.sequence_number
                    || got.accuracy_status !== want.accuracy_status
                    || got.x_value !== want.x_value
                    || got.y_value !== want.y_value
                    || got.z_value !== want.z_value
                    || got.real_value !== want.real_value
                    || got.heading_accuracy !== want.heading_accuracy
                    || got.packet_done !== want.packet_done
                    || got.any_report_found !== want.any_report_found)
                    note_error($sformatf("mismatch\n  expected %s\n  actual   %s",
                                         show(want), show(got)));
            end
        end
    end

    // present one beat, with random idle cycles ahead of it, and wait for it to be taken
    task automatic send_beat(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= it.data_byte;
        channel_number <= it.channel_number;
        first_of_packet <= it.first_of_packet;
        last_of_packet <= it.last_of_packet;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    task automatic feed_byte(input in_item_t it);
        result_t r;
        send_beat(it);
        if (decode_byte(it, r))
            pending_reports.push_back(r);
    endtask

    // sender holds off until every expected result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        chan_mask = value;
    endtask

    task automatic add_row(input logic [7:0] b, input logic [7:0] ch, input bit f, input bit l,
                           input check_e chk, input result_t want);
        script_row_t row;
        row.beat.data_byte = b;
        row.beat.channel_number = ch;
        row.beat.first_of_packet = f;
        row.beat.last_of_packet = l;
        row.chk = chk;
        row.want = want;
        script.push_back(row);
    endtask

    task automatic send_random_packet();
        logic [7:0] body [$];
        logic [7:0] chan;
        logic [7:0] rid;
        logic [2:0] kind;
        logic [3:0] len;
        int n_pad;
        int pick;
        int restart_at;
        in_item_t it;
        if (chan_mask != 0 && $urandom_range(7) != 0)
        begin
            do
                chan = 8'($urandom_range(7));
            while (!chan_mask[chan[2:0]]);
        end
        else
            chan = 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
        begin
            // noise packet
            repeat ($urandom_range(1, 20))
                body.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(3) == 0)
            begin
                body.push_back(ID_TIMESTAMP);
                repeat (4)
                    body.push_back(8'($urandom_range(255)));
            end
            repeat ($urandom_range(1, 3))
            begin
                pick = $urandom_range(19);
                if (pick < 14)
                    rid = SENSOR_IDS[$urandom_range(6)];
                else if (pick < 18)
                    rid = OTHER_IDS[$urandom_range(7)];
                else
                    rid = 8'($urandom_range(255));
                len = id_info(rid, kind);
                n_pad = (len == SIZE_UNKNOWN) ? $urandom_range(4) : int'(len) - 1;
                body.push_back(rid);
                repeat (n_pad)
                    body.push_back(8'($urandom_range(255)));
            end
            // cut the packet short now and then
            if ($urandom_range(7) == 0 && body.size() > 1)
                repeat ($urandom_range(1, body.size() - 1))
                    void'(body.pop_back());
        end
        if ($urandom_range(15) == 0)
        begin
            // stray beats outside any packet
            repeat ($urandom_range(1, 3))
            begin
                it.data_byte = 8'($urandom_range(255));
                it.channel_number = 8'($urandom_range(255));
                it.first_of_packet = 1'b0;
                it.last_of_packet = 1'($urandom_range(1));
                feed_byte(it);
            end
        end
        restart_at = (body.size() > 2 && $urandom_range(15) == 0)
                     ? $urandom_range(1, body.size() - 1) : -1;
        for (int i = 0; i < body.size(); i++)
        begin
            it.data_byte = body[i];
            it.first_of_packet = (i == 0) || (i == restart_at);
            it.channel_number = it.first_of_packet ? chan : 8'($urandom_range(255));
            it.last_of_packet = (i == body.size() - 1);
            feed_byte(it);
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("sensor_report_stream_parser verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] grav_body [13];
        result_t grav_want;
        result_t r;
        int n_directed;

        grav_body = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F,
                      8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78};
        grav_want = done_only(1'b1);
        grav_want.report_kind = KIND_GRAVITY;
        grav_want.sequence_number = 8'hFF;
        grav_want.accuracy_status = 2'd3;
        grav_want.x_value = -16'sd32768;
        grav_want.y_value = 16'sd32767;
        grav_want.z_value = -16'sd1;

        // stray last beat, then a one-beat packet on a channel that is never accepted
        add_row(8'h55, 8'h00, 1'b0, 1'b1, WANT_RESULT, done_only(1'b0));
        add_row(ID_ROT_VEC, 8'hFF, 1'b1, 1'b1, WANT_RESULT, done_only(1'b0));
        // timestamp record with no room left for a report
        add_row(ID_TIMESTAMP, 8'h03, 1'b1, 1'b0, WANT_NONE, '0);
        add_row(ID_ACCEL, 8'h00, 1'b0, 1'b0, WANT_NONE, '0);
        add_row(ID_GYRO, 8'h00, 1'b0, 1'b1, WANT_RESULT, done_only(1'b0));
        // id-only reports are skipped, an unknown id halts the rest
        add_row(ID_STAB_CLS, 8'h05, 1'b1, 1'b0, WANT_NONE, '0);
        add_row(ID_SHAKE, 8'h00, 1'b0, 1'b0, WANT_NONE, '0);
        add_row(8'h00, 8'h00, 1'b0, 1'b0, WANT_NONE, '0);
        add_row(ID_ACCEL, 8'h00, 1'b0, 1'b1, WANT_RESULT, done_only(1'b0));
        // gravity report completed on the last beat, field extremes
        add_row(ID_GRAVITY, 8'h04, 1'b1, 1'b0, WANT_NONE, '0);
        for (int i = 0; i < 12; i++)
            add_row(grav_body[i], 8'h00, 1'b0, 1'b0, WANT_NONE, '0);
        add_row(grav_body[12], 8'h00, 1'b0, 1'b1, WANT_RESULT, grav_want);
        // first mark in the middle of a report restarts the packet
        add_row(ID_ACCEL, 8'h03, 1'b1, 1'b0, BY_MODEL, '0);
        add_row(8'h22, 8'h00, 1'b0, 1'b0, BY_MODEL, '0);
        add_row(8'h33, 8'h03, 1'b1, 1'b1, BY_MODEL, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            send_beat(script[i].beat);
            if (decode_byte(script[i].beat, r) && script[i].chk == BY_MODEL)
                pending_reports.push_back(r);
            if (script[i].chk == WANT_RESULT)
                pending_reports.push_back(script[i].want);
        end
        drain();
        n_directed = beats_sent;

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_mask((p == 3) ? 8'($urandom_range(255)) : MASK_PLAN[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            while (beats_sent < n_directed + (p + 1) * BEATS_PER_PHASE)
                send_random_packet();
            drain();
        end

        repeat (8) @(posedge clk);
        error_count += pending_reports.size();
        if (error_count == 0)
            $display("sensor_report_stream_parser verification clean");
        else
            $display("sensor_report_stream_parser verification failed");
        $finish;
    end

endmodule

`default_nettype wire
